// ===== sv/swm_pkg.sv =====
// Shared types and fixed constants of the sliding-window median filter.
package swm_pkg;

    // Width of the window size config field (cfg_data), and the window size after reset
    localparam int unsigned CFG_BITS          = 7;
    localparam int unsigned WINDOW_SIZE_RESET = 3;

    // Flags one cell shows to its neighbours
    typedef struct packed {
        logic valid;    // cell holds a sample
        logic le;       // held sample <= incoming sample
    } cell_link_t;

endpackage

// ===== sv/swm_cell.sv =====
// One cell of the sorted chain: holds a sample and its age, shifts with its neighbours.
module swm_cell #(
    parameter int unsigned SAMPLE_BITS = 32,
    parameter int unsigned AW          = 6
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic                          valid,
    input  logic                          del_active,
    input  logic [AW-1:0]                 del_target,
    input  logic signed [SAMPLE_BITS-1:0] new_value,
    input  logic signed [SAMPLE_BITS-1:0] del_value,
    input  logic [AW-1:0]                 del_age,
    input  swm_pkg::cell_link_t           left_link,
    input  logic signed [SAMPLE_BITS-1:0] left_value,
    input  logic [AW-1:0]                 left_age,
    input  swm_pkg::cell_link_t           right_link,
    input  logic signed [SAMPLE_BITS-1:0] right_value,
    input  logic [AW-1:0]                 right_age,
    output swm_pkg::cell_link_t           link,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic [AW-1:0]                 age,
    output logic signed [SAMPLE_BITS-1:0] post_ins,
    output logic                          del_hit
);

    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic [AW-1:0]                 age_reg;
    logic [AW-1:0]                 age_next;
    logic                          le;
    logic                          right_of_del;
    logic                          ge_q;
    logic                          left_ge_p;
    logic                          right_ge_p;

    // Place this cell against the insert and the removal position
    always_comb
    begin
        le         = valid && (value_reg <= new_value);
        left_ge_p  = !left_link.le;
        right_ge_p = !right_link.le;
        if (del_active)
        begin
            del_hit      = valid && (age_reg == del_target);
            right_of_del = valid && ((value_reg > del_value) ||
                                     ((value_reg == del_value) && (age_reg < del_age)));
        end
        else
        begin
            // no removal: the first empty cell takes the extra entry
            del_hit      = !valid && left_link.valid;
            right_of_del = !valid && !left_link.valid;
        end
        ge_q = del_hit || right_of_del;
    end

    // Pick the next content: from the left, the new sample, from the right, or hold
    always_comb
    begin
        if (left_ge_p && !right_of_del)
        begin
            value_next = left_value;
            age_next   = left_age + AW'(1);
        end
        else if ((!le && !left_ge_p && !right_of_del) || (le && right_ge_p && ge_q))
        begin
            value_next = new_value;
            age_next   = '0;
        end
        else if (ge_q && !right_ge_p)
        begin
            value_next = right_value;
            age_next   = right_age + AW'(1);
        end
        else
        begin
            value_next = value_reg;
            age_next   = age_reg + AW'(1);
        end
    end

    // Sample and age store
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign link.valid = valid;
    assign link.le    = le;
    assign value      = value_reg;
    assign age        = age_reg;
    // content of this position once the new sample is in, before the removal
    assign post_ins   = le ? value_reg : (left_link.le ? new_value : left_value);

endmodule

// ===== sv/swm_out_buf.sv =====
// Output register with a skid stage for result items.
module swm_out_buf #(
    parameter int unsigned W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         can_push,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         out_valid_reg;
    logic [W-1:0] out_data_reg;
    logic         skid_valid_reg;
    logic [W-1:0] skid_data_reg;
    logic         pop;

    assign pop = out_valid_reg && out_ready;

    // Control: advance skid into output, park a new item when output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/sliding_window_median.sv =====
// Top level of the sliding-window median filter: chain of sorted cells and output buffer.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+--------------------------
//  s_*       | in        | s_tvalid / s_tready         | s_tdata: sample
//  m_*       | out       | m_tvalid / m_tready         | m_tdata: median
//  cfg_*     | in        | cfg_valid / cfg_ready       | cfg_data: window_size
//
//  One sample is taken every clock while s_tready is high; all cells compare and shift in the same cycle.
//  Once window_size-1 samples are held, a median is formed combinationally with its
//  sample and registered in the output register, or in the skid stage on a stall.
//  After reset or a window_size write the cells count as empty; no clearing pass.
//  s_tready drops only while both output register and skid stage hold items.
module sliding_window_median #(
    parameter int unsigned WINDOW_MAX  = 64,
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,   // [SAMPLE_BITS-1:0] sample
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,   // [SAMPLE_BITS-1:0] median
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [swm_pkg::CFG_BITS-1:0]           cfg_data   // window_size
);

    localparam int unsigned DW    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int unsigned AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned KW    = $clog2(WINDOW_MAX + 1);
    localparam int unsigned CMPW  = (KW > swm_pkg::CFG_BITS) ? KW : swm_pkg::CFG_BITS;
    localparam int unsigned K_RST = (swm_pkg::WINDOW_SIZE_RESET > WINDOW_MAX) ?
                                    WINDOW_MAX : swm_pkg::WINDOW_SIZE_RESET;

    logic [KW-1:0]                  k_reg;
    logic [KW-1:0]                  k_next;
    logic [KW-1:0]                  fill_reg;
    logic [KW-1:0]                  fill_next;
    logic [CMPW-1:0]                cfg_wide;
    logic                           accept;
    logic                           full;
    logic                           del_active;
    logic                           cell_en;
    logic [AW-1:0]                  del_target;
    logic [KW-1:0]                  mid_wide;
    logic [AW-1:0]                  mid;
    logic signed [SAMPLE_BITS-1:0]  new_value;
    logic signed [SAMPLE_BITS-1:0]  del_value;
    logic [AW-1:0]                  del_age;
    logic signed [SAMPLE_BITS-1:0]  median;

    swm_pkg::cell_link_t            link     [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0]  value    [WINDOW_MAX];
    logic [AW-1:0]                  age      [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0]  post_ins [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]          del_hit;
    logic [WINDOW_MAX-1:0]          valid;

    assign new_value  = s_tdata[SAMPLE_BITS-1:0];
    assign accept     = s_tvalid && s_tready;
    assign full       = (fill_reg == k_reg - KW'(1));
    assign del_active = full && (k_reg > KW'(1));
    assign cell_en    = accept && (k_reg > KW'(1));
    assign del_target = AW'(k_reg - KW'(2));
    assign mid_wide   = (k_reg - KW'(1)) >> 1;
    assign mid        = mid_wide[AW-1:0];
    assign cfg_ready  = 1'b1;
    assign cfg_wide   = CMPW'(cfg_data);

    // Clamp the written window size into 1..WINDOW_MAX
    always_comb
    begin
        if (cfg_wide == '0)
        begin
            k_next = KW'(1);
        end
        else if (cfg_wide > CMPW'(WINDOW_MAX))
        begin
            k_next = KW'(WINDOW_MAX);
        end
        else
        begin
            k_next = cfg_wide[KW-1:0];
        end
    end

    // Count held samples: grow until the window is one short of full, then hold
    always_comb
    begin
        fill_next = fill_reg;
        if (accept && !full)
        begin
            fill_next = fill_reg + KW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= KW'(K_RST);
            fill_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            k_reg    <= k_next;
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Chain of cells
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_pkg::cell_link_t           l_link;
        swm_pkg::cell_link_t           r_link;
        logic signed [SAMPLE_BITS-1:0] l_value;
        logic signed [SAMPLE_BITS-1:0] r_value;
        logic [AW-1:0]                 l_age;
        logic [AW-1:0]                 r_age;

        assign valid[i] = (KW'(i) < fill_reg);

        if (i == 0)
        begin : g_left_edge
            assign l_link.valid = 1'b1;
            assign l_link.le    = 1'b1;
            assign l_value      = '0;
            assign l_age        = '0;
        end
        else
        begin : g_left
            assign l_link  = link[i-1];
            assign l_value = value[i-1];
            assign l_age   = age[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_right_edge
            assign r_link.valid = 1'b0;
            assign r_link.le    = 1'b0;
            assign r_value      = '0;
            assign r_age        = '0;
        end
        else
        begin : g_right
            assign r_link  = link[i+1];
            assign r_value = value[i+1];
            assign r_age   = age[i+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AW          (AW)
        ) u_cell (
            .clk         (clk),
            .en          (cell_en),
            .valid       (valid[i]),
            .del_active  (del_active),
            .del_target  (del_target),
            .new_value   (new_value),
            .del_value   (del_value),
            .del_age     (del_age),
            .left_link   (l_link),
            .left_value  (l_value),
            .left_age    (l_age),
            .right_link  (r_link),
            .right_value (r_value),
            .right_age   (r_age),
            .link        (link[i]),
            .value       (value[i]),
            .age         (age[i]),
            .post_ins    (post_ins[i]),
            .del_hit     (del_hit[i])
        );
    end

    // Gather the sample to drop from the one matching cell
    always_comb
    begin
        del_value = '0;
        del_age   = '0;
        for (int j = 0; j < WINDOW_MAX; j++)
        begin
            if (del_hit[j])
            begin
                del_value = del_value | value[j];
                del_age   = del_age | age[j];
            end
        end
    end

    assign median = post_ins[mid];

    swm_out_buf #(
        .W (DW)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && full),
        .push_data (DW'($unsigned(median))),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // Held count stays below the window size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < k_reg)
        else $error("held count reached window size");

    // Removal finds exactly one cell
    a_del_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && del_active) |-> $onehot(del_hit))
        else $error("removal does not match exactly one cell");

    // A full window yields a result item on the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full) |=> m_tvalid)
        else $error("result item missing after full window");

endmodule
